[hw/rtl/rafe_pkg.sv]
`default_nettype none

package rafe_pkg;

	// fixed point format
	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = 32;
	localparam int DIR_W     = 18;

	// geometry widths
	localparam int DP_W  = VAL_W + 1;
	localparam int CP_W  = DIR_W + DP_W;
	localparam int C_W   = CP_W + 1;
	localparam int CM_W  = C_W - 1;
	localparam int CH_LO = (CM_W + 1) / 2;
	localparam int CH_HI = CM_W - CH_LO;
	localparam int DSQ_W = 2 * DP_W;
	localparam int SDP_W = DSQ_W + 2;

	// square root unit
	localparam int RAD_W  = 2 * CM_W;
	localparam int ROOT_W = CM_W;
	localparam int SQ_LAT = ROOT_W;
	localparam int LDP_W  = DP_W + 1;
	localparam int LC_LO  = (ROOT_W + 1) / 2;
	localparam int LC_HI  = ROOT_W - LC_LO;

	// divider
	localparam int DEN_W  = ROOT_W + LDP_W;
	localparam int NUM_W  = VAL_W + CM_W;
	localparam int NSH_W  = NUM_W + FRAC_BITS;
	localparam int N_W    = ((NSH_W > DEN_W) ? NSH_W : DEN_W) + 1;
	localparam int Q_W    = VAL_W;
	localparam int R_W    = DEN_W + Q_W;
	localparam int DV_LAT = Q_W + 1;

	// moment
	localparam int MP_W = DP_W + VAL_W;
	localparam int RD_W = VAL_W + DIR_W;
	localparam int M_W  = MP_W + 3;

	// register map
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_POINT_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_POINT_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_POINT_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_DIR_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_DIR_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_DIR_Z   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TORQUE       = 3'd6;

	typedef struct packed {
		logic                     degen;
		logic [2:0]               cneg;
		logic [2:0][CM_W-1:0]     cm;
		logic [2:0][DP_W-1:0]     dp;
	} pay_t;

	typedef struct packed {
		logic [VAL_W-1:0] force_x;
		logic [VAL_W-1:0] force_y;
		logic [VAL_W-1:0] force_z;
		logic [VAL_W-1:0] moment_x;
		logic [VAL_W-1:0] moment_y;
		logic [VAL_W-1:0] moment_z;
		logic             degenerate;
		logic             saturated;
	} res_t;

endpackage

`default_nettype wire

[hw/rtl/rafe_pos_if.sv]
`default_nettype none

interface rafe_pos_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] body_pos_x;
	logic signed [31:0] body_pos_y;
	logic signed [31:0] body_pos_z;

	modport source (output valid, output body_pos_x, output body_pos_y, output body_pos_z,
		input ready);
	modport sink (input valid, input body_pos_x, input body_pos_y, input body_pos_z,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/rafe_res_if.sv]
`default_nettype none

interface rafe_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic signed [31:0] force_z;
	logic signed [31:0] moment_x;
	logic signed [31:0] moment_y;
	logic signed [31:0] moment_z;
	logic               degenerate;
	logic               saturated;

	modport source (output valid, output force_x, output force_y, output force_z,
		output moment_x, output moment_y, output moment_z, output degenerate,
		output saturated, input ready);
	modport sink (input valid, input force_x, input force_y, input force_z,
		input moment_x, input moment_y, input moment_z, input degenerate,
		input saturated, output ready);
endinterface

`default_nettype wire

[hw/rtl/rafe_sqrt.sv]
`default_nettype none

module rafe_sqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [rafe_pkg::RAD_W-1:0]   rad,
	output logic [rafe_pkg::ROOT_W-1:0]  root
);
	import rafe_pkg::*;

	// one root bit per stage, msb first
	logic [RAD_W-1:0]  rem_q  [ROOT_W];
	logic [ROOT_W-1:0] root_q [ROOT_W];
	logic [RAD_W-1:0]  rin    [ROOT_W];
	logic [RAD_W-1:0]  rnx    [ROOT_W];
	logic [RAD_W-1:0]  trial  [ROOT_W];
	logic [ROOT_W-1:0] qin    [ROOT_W];
	logic [ROOT_W-1:0] qnx    [ROOT_W];

	always_comb begin
		for (int j = 0; j < ROOT_W; j++) begin
			if (j == 0) begin
				rin[j] = rad;
				qin[j] = '0;
			end else begin
				rin[j] = rem_q[j-1];
				qin[j] = root_q[j-1];
			end
			trial[j] = (RAD_W'(qin[j]) << (ROOT_W - j)) | (RAD_W'(1) << (2 * (ROOT_W - 1 - j)));
			if (rin[j] >= trial[j]) begin
				rnx[j] = rin[j] - trial[j];
				qnx[j] = qin[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
			end else begin
				rnx[j] = rin[j];
				qnx[j] = qin[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < ROOT_W; j++) begin
				rem_q[j]  <= rnx[j];
				root_q[j] <= qnx[j];
			end
		end
	end

	assign root = root_q[ROOT_W-1];

endmodule

`default_nettype wire

[hw/rtl/rafe_div.sv]
`default_nettype none

module rafe_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [rafe_pkg::N_W-1:0]    num,
	input  logic [rafe_pkg::DEN_W-1:0]  den,
	output logic [rafe_pkg::Q_W-1:0]    quo,
	output logic                        ovf
);
	import rafe_pkg::*;

	// stage 0 checks quotient range, then one quotient bit per stage
	logic [R_W-1:0]   rem_q [Q_W+1];
	logic [DEN_W-1:0] den_q [Q_W+1];
	logic [Q_W-1:0]   quo_q [Q_W+1];
	logic             ovf_q [Q_W+1];
	logic [R_W-1:0]   rnx   [Q_W+1];
	logic [Q_W-1:0]   qnx   [Q_W+1];
	logic [R_W-1:0]   dsh   [Q_W+1];
	logic             onx;

	always_comb begin
		dsh[0] = R_W'(den) << Q_W;
		onx    = R_W'(num) >= dsh[0];
		rnx[0] = R_W'(num);
		qnx[0] = '0;
		for (int j = 1; j <= Q_W; j++) begin
			dsh[j] = R_W'(den_q[j-1]) << (Q_W - j);
			if (rem_q[j-1] >= dsh[j]) begin
				rnx[j] = rem_q[j-1] - dsh[j];
				qnx[j] = quo_q[j-1] | (Q_W'(1) << (Q_W - j));
			end else begin
				rnx[j] = rem_q[j-1];
				qnx[j] = quo_q[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q[0] <= den;
			ovf_q[0] <= onx;
			for (int j = 0; j <= Q_W; j++) begin
				rem_q[j] <= rnx[j];
				quo_q[j] <= qnx[j];
			end
			for (int j = 1; j <= Q_W; j++) begin
				den_q[j] <= den_q[j-1];
				ovf_q[j] <= ovf_q[j-1];
			end
		end
	end

	assign quo = quo_q[Q_W];
	assign ovf = ovf_q[Q_W];

endmodule

`default_nettype wire

[hw/rtl/rotational_axial_force_eval_top.sv]
`default_nettype none

// rotational axial force evaluator
// pos channel (sink): one body position word, three signed Q16.16 coordinates
// res channel (source): force and moment vectors, degenerate and saturated flags
// cfg port: cfg_wr_en, cfg_index, cfg_data write axis point, axis direction and
//   torque; write them only while no word is in flight
// fully pipelined: one position word per cycle while the skid register is empty;
//   stages: 5 setup stages, 51-stage square root, 3 stages, 33-stage divider,
//   3 moment stages, output register
// the square root resolves one root bit per stage and the divider one quotient
//   bit per stage; these two units set the latency
// when the receiver stalls, the word in the output register holds and the
//   next finished word lands in a skid register; while the skid is full the
//   whole pipeline freezes and pos.ready is low, nothing is lost or repeated
// reset clears all valid bits and all configuration registers to zero
// dp zero or parallel to the axis gives zero outputs with degenerate set
module rotational_axial_force_eval_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [rafe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rafe_pkg::VAL_W-1:0]         cfg_data,
	rafe_pos_if.sink                           pos,
	rafe_res_if.source                         res
);
	import rafe_pkg::*;

	// configuration registers
	logic signed [VAL_W-1:0] pt_q  [3];
	logic signed [DIR_W-1:0] dir_q [3];
	logic signed [VAL_W-1:0] torque_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q     <= '{default: '0};
			dir_q    <= '{default: '0};
			torque_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_AXIS_POINT_X: pt_q[0]  <= signed'(cfg_data);
				CFG_AXIS_POINT_Y: pt_q[1]  <= signed'(cfg_data);
				CFG_AXIS_POINT_Z: pt_q[2]  <= signed'(cfg_data);
				CFG_AXIS_DIR_X:   dir_q[0] <= signed'(cfg_data[DIR_W-1:0]);
				CFG_AXIS_DIR_Y:   dir_q[1] <= signed'(cfg_data[DIR_W-1:0]);
				CFG_AXIS_DIR_Z:   dir_q[2] <= signed'(cfg_data[DIR_W-1:0]);
				CFG_TORQUE:       torque_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// global advance: pipeline moves unless the skid register is occupied
	logic adv;
	logic out_v_q, skid_v_q;
	res_t out_q, skid_q, res_c;

	assign adv       = !skid_v_q;
	assign pos.ready = adv;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_sq [SQ_LAT];
	logic v_dv [DV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11} <= '0;
			v_sq <= '{default: 1'b0};
			v_dv <= '{default: 1'b0};
		end else if (adv) begin
			v_s1 <= pos.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_sq[0] <= v_s5;
			for (int i = 1; i < SQ_LAT; i++) v_sq[i] <= v_sq[i-1];
			v_s6 <= v_sq[SQ_LAT-1];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_dv[0] <= v_s8;
			for (int i = 1; i < DV_LAT; i++) v_dv[i] <= v_dv[i-1];
			v_s9  <= v_dv[DV_LAT-1];
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// stage 1: offset from the axis point
	logic signed [VAL_W-1:0] pin [3];
	logic signed [DP_W-1:0]  dp_s1 [3];

	assign pin[0] = pos.body_pos_x;
	assign pin[1] = pos.body_pos_y;
	assign pin[2] = pos.body_pos_z;

	// stage 2: cross product terms
	logic signed [CP_W-1:0] pa_s2 [3];
	logic signed [CP_W-1:0] pb_s2 [3];
	logic signed [DP_W-1:0] dp_s2 [3];

	// stage 3: c = cross(dir, dp)
	logic signed [C_W-1:0]  c_s3  [3];
	logic signed [DP_W-1:0] dp_s3 [3];

	// stage 4: squares, |c|^2 split into partial products
	logic [DSQ_W-1:0]         dsq_s4 [3];
	logic [2*CH_HI-1:0]       chh_s4 [3];
	logic [CH_HI+CH_LO-1:0]   chl_s4 [3];
	logic [2*CH_LO-1:0]       cll_s4 [3];
	pay_t                     pay_s4;

	// stage 5: sums of squares
	logic [SDP_W-1:0] sdp_s5;
	logic [RAD_W-1:0] sc_s5;
	pay_t             pay_s5;

	logic [DP_W-1:0] dpm3 [3];
	logic [CM_W-1:0] cm3  [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dpm3[k] = dp_s3[k][DP_W-1] ? DP_W'(-dp_s3[k]) : DP_W'(dp_s3[k]);
			cm3[k]  = c_s3[k][C_W-1] ? CM_W'(-c_s3[k]) : CM_W'(c_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				dp_s1[k] <= DP_W'(pin[k]) - DP_W'(pt_q[k]);
				dp_s2[k] <= dp_s1[k];
				dp_s3[k] <= dp_s2[k];
				c_s3[k]  <= C_W'(pa_s2[k]) - C_W'(pb_s2[k]);
				dsq_s4[k] <= dpm3[k] * dpm3[k];
				chh_s4[k] <= cm3[k][CM_W-1:CH_LO] * cm3[k][CM_W-1:CH_LO];
				chl_s4[k] <= cm3[k][CM_W-1:CH_LO] * cm3[k][CH_LO-1:0];
				cll_s4[k] <= cm3[k][CH_LO-1:0] * cm3[k][CH_LO-1:0];
				pay_s4.cm[k]   <= cm3[k];
				pay_s4.cneg[k] <= c_s3[k][C_W-1];
				pay_s4.dp[k]   <= dp_s3[k];
			end
			pa_s2[0] <= dir_q[1] * dp_s1[2];
			pb_s2[0] <= dir_q[2] * dp_s1[1];
			pa_s2[1] <= dir_q[2] * dp_s1[0];
			pb_s2[1] <= dir_q[0] * dp_s1[2];
			pa_s2[2] <= dir_q[0] * dp_s1[1];
			pb_s2[2] <= dir_q[1] * dp_s1[0];
			pay_s4.degen <= (c_s3[0] == '0) && (c_s3[1] == '0) && (c_s3[2] == '0);
			sdp_s5 <= SDP_W'(dsq_s4[0]) + SDP_W'(dsq_s4[1]) + SDP_W'(dsq_s4[2]);
			sc_s5  <= (RAD_W'(chh_s4[0]) << (2 * CH_LO)) + (RAD_W'(chl_s4[0]) << (CH_LO + 1))
				+ RAD_W'(cll_s4[0])
				+ (RAD_W'(chh_s4[1]) << (2 * CH_LO)) + (RAD_W'(chl_s4[1]) << (CH_LO + 1))
				+ RAD_W'(cll_s4[1])
				+ (RAD_W'(chh_s4[2]) << (2 * CH_LO)) + (RAD_W'(chl_s4[2]) << (CH_LO + 1))
				+ RAD_W'(cll_s4[2]);
			pay_s5 <= pay_s4;
		end
	end

	// square roots of |c|^2 and |dp|^2
	logic [ROOT_W-1:0] lc, ldp_full;
	pay_t              pay_sq [SQ_LAT];

	rafe_sqrt u_sqrt_c (
		.clk  (clk),
		.en   (adv),
		.rad  (sc_s5),
		.root (lc)
	);

	rafe_sqrt u_sqrt_dp (
		.clk  (clk),
		.en   (adv),
		.rad  (RAD_W'(sdp_s5)),
		.root (ldp_full)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_sq[0] <= pay_s5;
			for (int i = 1; i < SQ_LAT; i++) pay_sq[i] <= pay_sq[i-1];
		end
	end

	// stage 6: partial products of denominator and numerators
	// stage 7: assembled denominator and numerators
	// stage 8: numerator plus half the denominator for rounding
	logic [LDP_W-1:0]             ldp;
	logic [VAL_W-1:0]             rmag;
	logic [LC_HI+LDP_W-1:0]       dh_s6;
	logic [LC_LO+LDP_W-1:0]       dl_s6;
	logic [VAL_W+CH_HI-1:0]       nh_s6 [3];
	logic [VAL_W+CH_LO-1:0]       nl_s6 [3];
	pay_t                         pay_s6, pay_s7, pay_s8;
	logic [DEN_W-1:0]             den_s7, den_s8;
	logic [NUM_W-1:0]             num_s7 [3];
	logic [N_W-1:0]               n_s8 [3];

	assign ldp  = ldp_full[LDP_W-1:0];
	assign rmag = torque_q[VAL_W-1] ? VAL_W'(-torque_q) : VAL_W'(torque_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			dh_s6 <= lc[ROOT_W-1:LC_LO] * ldp;
			dl_s6 <= lc[LC_LO-1:0] * ldp;
			for (int k = 0; k < 3; k++) begin
				nh_s6[k]  <= rmag * pay_sq[SQ_LAT-1].cm[k][CM_W-1:CH_LO];
				nl_s6[k]  <= rmag * pay_sq[SQ_LAT-1].cm[k][CH_LO-1:0];
				num_s7[k] <= (NUM_W'(nh_s6[k]) << CH_LO) + NUM_W'(nl_s6[k]);
				n_s8[k]   <= (N_W'(num_s7[k]) << FRAC_BITS) + N_W'(den_s7 >> 1);
			end
			den_s7 <= (DEN_W'(dh_s6) << LC_LO) + DEN_W'(dl_s6);
			den_s8 <= den_s7;
			pay_s6 <= pay_sq[SQ_LAT-1];
			pay_s7 <= pay_s6;
			pay_s8 <= pay_s7;
		end
	end

	// three dividers, one per force component
	logic [Q_W-1:0] quo [3];
	logic           ovf [3];
	pay_t           pay_dv [DV_LAT];

	for (genvar k = 0; k < 3; k++) begin : g_div
		rafe_div u_div (
			.clk (clk),
			.en  (adv),
			.num (n_s8[k]),
			.den (den_s8),
			.quo (quo[k]),
			.ovf (ovf[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_dv[0] <= pay_s8;
			for (int i = 1; i < DV_LAT; i++) pay_dv[i] <= pay_dv[i-1];
		end
	end

	// stage 9: signed, saturated force
	logic signed [VAL_W-1:0] fval [3];
	logic [2:0]              fsat;
	logic                    fneg [3];

	localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			fneg[k] = torque_q[VAL_W-1] ^ pay_dv[DV_LAT-1].cneg[k];
			if (fneg[k]) begin
				fsat[k] = ovf[k] || (quo[k][Q_W-1] && (quo[k][Q_W-2:0] != '0));
				fval[k] = fsat[k] ? signed'(VMIN) : signed'(VAL_W'(-quo[k]));
			end else begin
				fsat[k] = ovf[k] || quo[k][Q_W-1];
				fval[k] = fsat[k] ? signed'(VMAX) : signed'(quo[k]);
			end
		end
	end

	logic signed [VAL_W-1:0] f_s9 [3], f_s10 [3], f_s11 [3];
	logic signed [DP_W-1:0]  dp_s9 [3];
	logic                    fs_s9, fs_s10, fs_s11;
	logic                    dg_s9, dg_s10, dg_s11;

	// stage 10: moment products, stage 11: moment sums
	logic signed [MP_W-1:0] ma_s10 [3];
	logic signed [MP_W-1:0] mb_s10 [3];
	logic signed [RD_W-1:0] rd_s10 [3];
	logic signed [M_W-1:0]  m_s11 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				f_s9[k]  <= fval[k];
				dp_s9[k] <= signed'(pay_dv[DV_LAT-1].dp[k]);
				rd_s10[k] <= torque_q * dir_q[k];
				m_s11[k] <= M_W'(ma_s10[k]) - M_W'(mb_s10[k]) + M_W'(rd_s10[k]);
			end
			fs_s9 <= |fsat;
			dg_s9 <= pay_dv[DV_LAT-1].degen;
			ma_s10[0] <= dp_s9[2] * f_s9[1];
			mb_s10[0] <= dp_s9[1] * f_s9[2];
			ma_s10[1] <= dp_s9[0] * f_s9[2];
			mb_s10[1] <= dp_s9[2] * f_s9[0];
			ma_s10[2] <= dp_s9[1] * f_s9[0];
			mb_s10[2] <= dp_s9[0] * f_s9[1];
			f_s10  <= f_s9;
			fs_s10 <= fs_s9;
			dg_s10 <= dg_s9;
			f_s11  <= f_s10;
			fs_s11 <= fs_s10;
			dg_s11 <= dg_s10;
		end
	end

	// rounding half up and saturation of the moments
	logic signed [M_W-1:0]   mr [3];
	logic signed [M_W-1:0]   msh [3];
	logic signed [VAL_W-1:0] mval [3];
	logic [2:0]              msat;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mr[k]  = m_s11[k] + signed'(M_W'(1) << (FRAC_BITS - 1));
			msh[k] = mr[k] >>> FRAC_BITS;
			msat[k] = (msh[k][M_W-1:VAL_W-1] != '0) && (msh[k][M_W-1:VAL_W-1] != '1);
			if (msat[k]) begin
				mval[k] = msh[k][M_W-1] ? signed'(VMIN) : signed'(VMAX);
			end else begin
				mval[k] = msh[k][VAL_W-1:0];
			end
		end
		res_c.degenerate = dg_s11;
		res_c.saturated  = !dg_s11 && (fs_s11 || (|msat));
		res_c.force_x    = dg_s11 ? '0 : f_s11[0];
		res_c.force_y    = dg_s11 ? '0 : f_s11[1];
		res_c.force_z    = dg_s11 ? '0 : f_s11[2];
		res_c.moment_x   = dg_s11 ? '0 : mval[0];
		res_c.moment_y   = dg_s11 ? '0 : mval[1];
		res_c.moment_z   = dg_s11 ? '0 : mval[2];
	end

	// output register with skid
	logic take, pipe_in;

	assign take    = out_v_q && res.ready;
	assign pipe_in = adv && v_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= pipe_in;
			end
		end else if (!out_v_q) begin
			out_v_q <= pipe_in;
		end else if (pipe_in) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_v_q ? skid_q : res_c;
		end else if (!out_v_q) begin
			out_q <= res_c;
		end else if (pipe_in) begin
			skid_q <= res_c;
		end
	end

	assign res.valid      = out_v_q;
	assign res.force_x    = signed'(out_q.force_x);
	assign res.force_y    = signed'(out_q.force_y);
	assign res.force_z    = signed'(out_q.force_z);
	assign res.moment_x   = signed'(out_q.moment_x);
	assign res.moment_y   = signed'(out_q.moment_y);
	assign res.moment_z   = signed'(out_q.moment_z);
	assign res.degenerate = out_q.degenerate;
	assign res.saturated  = out_q.saturated;

	// skid only holds a word behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word without output word");

	// skid fills only when the output word was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !res.ready))
		else $error("skid filled without a stall");

	// degenerate words carry zero vectors and no saturation
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.degenerate) |-> (out_q.force_x == '0 && out_q.force_y == '0
		&& out_q.force_z == '0 && out_q.moment_x == '0 && out_q.moment_y == '0
		&& out_q.moment_z == '0 && !out_q.saturated))
		else $error("degenerate word with nonzero payload");

endmodule

`default_nettype wire

[sim/tb.sv]
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rafe_pkg::*;

	localparam int LATENCY = 95;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 320;

	// scoreboard: mirror of the register file plus the queue of pending force words
	class force_scoreboard;
		logic signed [31:0] axis_pt [3];
		logic signed [17:0] axis_dir [3];
		logic signed [31:0] torque;
		res_t pending_res [$];
		int errors;

		function new();
			foreach (axis_pt[k]) axis_pt[k] = '0;
			foreach (axis_dir[k]) axis_dir[k] = '0;
			torque = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				CFG_AXIS_POINT_X: axis_pt[0] = data;
				CFG_AXIS_POINT_Y: axis_pt[1] = data;
				CFG_AXIS_POINT_Z: axis_pt[2] = data;
				CFG_AXIS_DIR_X: axis_dir[0] = data[17:0];
				CFG_AXIS_DIR_Y: axis_dir[1] = data[17:0];
				CFG_AXIS_DIR_Z: axis_dir[2] = data[17:0];
				CFG_TORQUE: torque = data;
				default: ;
			endcase
		endfunction

		function logic [127:0] root_floor(logic [127:0] n);
			logic [127:0] acc, trial;
			acc = '0;
			for (int i = 63; i >= 0; i--) begin
				trial = acc | (128'd1 << i);
				if (trial * trial <= n) acc = trial;
			end
			return acc;
		endfunction

		function logic [31:0] clamp_moment(logic signed [127:0] v, inout bit sat);
			logic signed [127:0] t;
			t = (v + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (t > 128'sh7fffffff) begin
				sat = 1;
				return 32'h7fffffff;
			end
			if (t < -128'sh80000000) begin
				sat = 1;
				return 32'h80000000;
			end
			return t[31:0];
		endfunction

		function res_t compute_force(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
			logic signed [127:0] dp [3], dir [3], c [3], f [3], r, m [3], neg_q;
			logic [127:0] sdp, sc, ldp, lc, den, num, q, cmag, rmag;
			bit sat, neg;
			res_t o;
			o = '0;
			sat = 0;
			dp[0] = px;
			dp[1] = py;
			dp[2] = pz;
			for (int k = 0; k < 3; k++) begin
				dp[k] = dp[k] - axis_pt[k];
				dir[k] = axis_dir[k];
			end
			r = torque;
			c[0] = dir[1] * dp[2] - dir[2] * dp[1];
			c[1] = dir[2] * dp[0] - dir[0] * dp[2];
			c[2] = dir[0] * dp[1] - dir[1] * dp[0];
			// axis normal vanishes: zero outputs, flag only
			if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
				o.degenerate = 1'b1;
				return o;
			end
			sdp = dp[0] * dp[0] + dp[1] * dp[1] + dp[2] * dp[2];
			sc = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
			ldp = root_floor(sdp);
			lc = root_floor(sc);
			den = lc * ldp;
			rmag = (r < 0) ? -r : r;
			for (int k = 0; k < 3; k++) begin
				cmag = (c[k] < 0) ? -c[k] : c[k];
				num = (rmag * cmag) << FRAC_BITS;
				q = (num + (den >> 1)) / den;
				neg = (r < 0) != (c[k] < 0);
				neg_q = q;
				if (q == 0) begin
					f[k] = 0;
				end else if (!neg) begin
					if (q > 128'h7fffffff) begin
						sat = 1;
						f[k] = 128'sh7fffffff;
					end else begin
						f[k] = neg_q;
					end
				end else begin
					if (q > 128'h80000000) begin
						sat = 1;
						f[k] = -128'sh80000000;
					end else begin
						f[k] = -neg_q;
					end
				end
			end
			o.force_x = f[0][31:0];
			o.force_y = f[1][31:0];
			o.force_z = f[2][31:0];
			m[0] = dp[2] * f[1] - dp[1] * f[2] + r * dir[0];
			m[1] = dp[0] * f[2] - dp[2] * f[0] + r * dir[1];
			m[2] = dp[1] * f[0] - dp[0] * f[1] + r * dir[2];
			o.moment_x = clamp_moment(m[0], sat);
			o.moment_y = clamp_moment(m[1], sat);
			o.moment_z = clamp_moment(m[2], sat);
			o.saturated = sat;
			return o;
		endfunction

		function void note_position(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
			pending_res.push_back(compute_force(px, py, pz));
		endfunction

		function void check_result(res_t act);
			res_t exp_r;
			if (pending_res.size() == 0) begin
				$error("result word with nothing pending");
				errors++;
				return;
			end
			exp_r = pending_res.pop_front();
			if (act.force_x !== exp_r.force_x) begin
				$error("force_x exp %h got %h", exp_r.force_x, act.force_x); errors++;
			end
			if (act.force_y !== exp_r.force_y) begin
				$error("force_y exp %h got %h", exp_r.force_y, act.force_y); errors++;
			end
			if (act.force_z !== exp_r.force_z) begin
				$error("force_z exp %h got %h", exp_r.force_z, act.force_z); errors++;
			end
			if (act.moment_x !== exp_r.moment_x) begin
				$error("moment_x exp %h got %h", exp_r.moment_x, act.moment_x); errors++;
			end
			if (act.moment_y !== exp_r.moment_y) begin
				$error("moment_y exp %h got %h", exp_r.moment_y, act.moment_y); errors++;
			end
			if (act.moment_z !== exp_r.moment_z) begin
				$error("moment_z exp %h got %h", exp_r.moment_z, act.moment_z); errors++;
			end
			if (act.degenerate !== exp_r.degenerate) begin
				$error("degenerate exp %b got %b", exp_r.degenerate, act.degenerate); errors++;
			end
			if (act.saturated !== exp_r.saturated) begin
				$error("saturated exp %b got %b", exp_r.saturated, act.saturated); errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0] cfg_data;
	bit no_idle;
	int stall_cnt;
	force_scoreboard sb;

	rafe_pos_if pos ();
	rafe_res_if res ();

	rotational_axial_force_eval_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pos       (pos.sink),
		.res       (res.source)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// receiver: ready toggles at the falling edge, words checked at the rising edge
	always @(negedge clk) begin
		res.ready <= no_idle || ($urandom_range(99) >= 24);
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			sb.check_result({res.force_x, res.force_y, res.force_z, res.moment_x,
				res.moment_y, res.moment_z, res.degenerate, res.saturated});
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((pos.valid && pos.ready) || (res.valid && res.ready)) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("[rotational_axial_force_eval_top] ERROR");
				$finish;
			end
		end
	end

	// one register write per falling edge; caller drops the enable afterwards
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic load_axis(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
		logic [31:0] dx, logic [31:0] dy, logic [31:0] dz, logic [31:0] tq);
		write_reg(CFG_AXIS_POINT_X, px);
		write_reg(CFG_AXIS_POINT_Y, py);
		write_reg(CFG_AXIS_POINT_Z, pz);
		write_reg(CFG_AXIS_DIR_X, dx);
		write_reg(CFG_AXIS_DIR_Y, dy);
		write_reg(CFG_AXIS_DIR_Z, dz);
		write_reg(CFG_TORQUE, tq);
		// index past the map, must be ignored
		write_reg(CFG_IDX_W'(7), $urandom);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// sender: random idle cycles, then hold the word until accepted
	task automatic send_pos(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		while (!no_idle && $urandom_range(99) < 24) begin
			pos.valid <= 1'b0;
			@(negedge clk);
		end
		pos.valid <= 1'b1;
		pos.body_pos_x <= px;
		pos.body_pos_y <= py;
		pos.body_pos_z <= pz;
		@(posedge clk);
		while (!pos.ready) @(posedge clk);
		sb.note_position(px, py, pz);
		@(negedge clk);
	endtask

	// wait for the pipeline to drain before touching the registers
	task automatic drain();
		pos.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending_res.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	// random direction component: mostly within +-1.0, sometimes any 18-bit value
	function automatic logic [31:0] rand_dir();
		case ($urandom_range(5))
			0: return 32'($signed(-18'sd65536));
			1: return 32'd65536;
			2: return $urandom;
			default: return 32'($signed(18'($urandom_range(131072)) - 18'sd65536));
		endcase
	endfunction

	function automatic logic [31:0] near_point(logic [31:0] base);
		case ($urandom_range(3))
			0: return base + 32'($urandom_range(255)) - 32'd128;
			1: return base + 32'($urandom_range(1 << 21)) - 32'(1 << 20);
			default: return base + 32'($urandom_range(1 << 26)) - 32'(1 << 25);
		endcase
	endfunction

	initial begin
		logic [31:0] ax, ay, az;
		sb = new();
		arst_n = 1'b0;
		no_idle = 1'b0;
		stall_cnt = 0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pos.valid = 1'b0;
		pos.body_pos_x = '0;
		pos.body_pos_y = '0;
		pos.body_pos_z = '0;
		res.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset registers: zero direction, every word degenerate
		send_pos(32'h7fffffff, 32'h80000000, 32'h00010000);
		send_pos(32'h0, 32'h0, 32'h0);

		// unit z axis through origin, unit torque
		drain();
		load_axis(0, 0, 0, 0, 0, 32'd65536, 32'd65536);
		send_pos(32'h00010000, 32'h0, 32'h0);
		send_pos(32'h0, 32'hffff0000, 32'h00050000);
		send_pos(32'h0, 32'h0, 32'h00030000);       // on the axis
		send_pos(32'h0, 32'h0, 32'h0);              // at the axis point
		send_pos(32'h00000001, 32'h0, 32'h0);       // tiny radius, force clamps
		send_pos(32'h7fffffff, 32'h7fffffff, 32'h80000000);
		send_pos(32'h80000000, 32'h80000000, 32'h7fffffff);
		send_pos(32'h00000001, 32'h00000001, 32'h0);

		// extreme registers: widest dp, full negative torque, tilted axis
		drain();
		load_axis(32'h80000000, 32'h7fffffff, 32'h80000000, 32'($signed(-18'sd65536)),
			32'd65536, 32'h0001ffff, 32'h80000000);
		send_pos(32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send_pos(32'h80000000, 32'h7fffffff, 32'h80000000);
		send_pos(32'h80000001, 32'h7fffffff, 32'h80000000);
		send_pos(32'h0, 32'h0, 32'h0);
		drain();
		load_axis(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h0001ffff,
			32'h00020000, 32'h0, 32'h7fffffff);
		send_pos(32'h80000000, 32'h7fffffff, 32'h80000000);
		send_pos(32'h7ffffffe, 32'h80000001, 32'h7fffffff);
		send_pos(32'h7fffffff, 32'h80000000, 32'h7fffffff);

		// random phases with fresh registers each time
		for (int p = 0; p < PHASES; p++) begin
			drain();
			ax = (p == 1) ? 32'h0 : $urandom;
			ay = (p == 1) ? 32'h0 : $urandom;
			az = (p == 1) ? 32'h0 : $urandom;
			load_axis(ax, ay, az, rand_dir(), rand_dir(), rand_dir(),
				(p == PHASES - 1) ? 32'h7fffffff : $urandom);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// first phase runs its first half with no idling on either side
				no_idle = (p == 0) && (i < ITEMS_PER_PHASE / 2);
				// sender holds off until the pipeline is empty once
				if (p == 2 && i == ITEMS_PER_PHASE / 2) begin
					pos.valid <= 1'b0;
					@(negedge clk);
					while (sb.pending_res.size() != 0) @(negedge clk);
				end
				case ($urandom_range(9))
					0: send_pos($urandom, $urandom, $urandom);
					1: send_pos(ax, ay, az);
					default: send_pos(near_point(ax), near_point(ay), near_point(az));
				endcase
			end
		end
		no_idle = 1'b0;
		pos.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending_res.size() != 0) @(negedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[rotational_axial_force_eval_top] OK");
		end else begin
			$display("[rotational_axial_force_eval_top] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
